FILE: hw/rtl/mhpq_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and the control store of the max-heap priority queue.
// No dependencies; imported by every module of the block.
package mhpq_pkg;

  localparam int MHPQ_CAPACITY = 64;
  localparam int UPC_W         = 4;
  localparam int KEY_W         = 32;
  localparam int TOTAL_W       = 7;

  localparam logic       OP_INSERT = 1'b0;
  localparam logic       OP_REMOVE = 1'b1;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic                    operation;
    logic signed [KEY_W-1:0] data_value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]              status;
    logic signed [KEY_W-1:0] removed_value;
    logic [TOTAL_W-1:0]      entry_total;
  } out_item_t;

  typedef enum logic [3:0] {
    C_NEVER    = 4'd0,
    C_ALWAYS   = 4'd1,
    C_NO_BEAT  = 4'd2,
    C_IS_INS   = 4'd3,
    C_ERR      = 4'd4,
    C_LAST_ONE = 4'd5,
    C_NO_LEFT  = 4'd6,
    C_DN_MOVE  = 4'd7,
    C_AT_ROOT  = 4'd8,
    C_UP_MOVE  = 4'd9,
    C_OUT_FREE = 4'd10
  } cond_t;

  typedef enum logic [2:0] {
    A_NONE      = 3'd0,
    A_LOAD      = 3'd1,
    A_REM_START = 3'd2,
    A_DN_STEP   = 3'd3,
    A_INS_START = 3'd4,
    A_UP_STEP   = 3'd5,
    A_PLACE     = 3'd6,
    A_EMIT      = 3'd7
  } act_t;

  typedef enum logic [1:0] {
    R_NONE      = 2'd0,
    R_ROOT_LAST = 2'd1,
    R_CHILDREN  = 2'd2,
    R_PARENT    = 2'd3
  } rd_t;

  typedef struct packed {
    cond_t            cond;
    logic [UPC_W-1:0] target;
    rd_t              rd;
    act_t             act;
  } uword_t;

  typedef struct packed {
    rd_t  rd;
    act_t act;
    logic idle;
  } ctrl_t;

  typedef struct packed {
    logic err;
    logic is_ins;
    logic last_one;
    logic no_left;
    logic dn_move;
    logic at_root;
    logic up_move;
    logic out_free;
  } flags_t;

  localparam logic [UPC_W-1:0] PC_IDLE     = 4'd0;
  localparam logic [UPC_W-1:0] PC_DISP     = 4'd1;
  localparam logic [UPC_W-1:0] PC_REM_CHK  = 4'd2;
  localparam logic [UPC_W-1:0] PC_REM_RD   = 4'd3;
  localparam logic [UPC_W-1:0] PC_REM_GO   = 4'd4;
  localparam logic [UPC_W-1:0] PC_DN_RD    = 4'd5;
  localparam logic [UPC_W-1:0] PC_DN_CMP   = 4'd6;
  localparam logic [UPC_W-1:0] PC_DN_DONE  = 4'd7;
  localparam logic [UPC_W-1:0] PC_INS_CHK  = 4'd8;
  localparam logic [UPC_W-1:0] PC_INS_GO   = 4'd9;
  localparam logic [UPC_W-1:0] PC_UP_RD    = 4'd10;
  localparam logic [UPC_W-1:0] PC_UP_CMP   = 4'd11;
  localparam logic [UPC_W-1:0] PC_PLACE    = 4'd12;
  localparam logic [UPC_W-1:0] PC_EMIT     = 4'd13;
  localparam logic [UPC_W-1:0] PC_EMIT_W   = 4'd14;

  // taken condition jumps to target, otherwise fall through to pc + 1
  function automatic uword_t ucode(logic [UPC_W-1:0] pc);
    uword_t w;
    w = '{cond: C_ALWAYS, target: PC_IDLE, rd: R_NONE, act: A_NONE};
    case (pc)
      PC_IDLE:    w = '{cond: C_NO_BEAT,  target: PC_IDLE,   rd: R_NONE,      act: A_LOAD};
      PC_DISP:    w = '{cond: C_IS_INS,   target: PC_INS_CHK, rd: R_NONE,     act: A_NONE};
      PC_REM_CHK: w = '{cond: C_ERR,      target: PC_EMIT,   rd: R_NONE,      act: A_NONE};
      PC_REM_RD:  w = '{cond: C_NEVER,    target: PC_IDLE,   rd: R_ROOT_LAST, act: A_NONE};
      PC_REM_GO:  w = '{cond: C_LAST_ONE, target: PC_EMIT,   rd: R_NONE,      act: A_REM_START};
      PC_DN_RD:   w = '{cond: C_NO_LEFT,  target: PC_PLACE,  rd: R_CHILDREN,  act: A_NONE};
      PC_DN_CMP:  w = '{cond: C_DN_MOVE,  target: PC_DN_RD,  rd: R_NONE,      act: A_DN_STEP};
      PC_DN_DONE: w = '{cond: C_ALWAYS,   target: PC_PLACE,  rd: R_NONE,      act: A_NONE};
      PC_INS_CHK: w = '{cond: C_ERR,      target: PC_EMIT,   rd: R_NONE,      act: A_NONE};
      PC_INS_GO:  w = '{cond: C_NEVER,    target: PC_IDLE,   rd: R_NONE,      act: A_INS_START};
      PC_UP_RD:   w = '{cond: C_AT_ROOT,  target: PC_PLACE,  rd: R_PARENT,    act: A_NONE};
      PC_UP_CMP:  w = '{cond: C_UP_MOVE,  target: PC_UP_RD,  rd: R_NONE,      act: A_UP_STEP};
      PC_PLACE:   w = '{cond: C_NEVER,    target: PC_IDLE,   rd: R_NONE,      act: A_PLACE};
      PC_EMIT:    w = '{cond: C_OUT_FREE, target: PC_IDLE,   rd: R_NONE,      act: A_EMIT};
      PC_EMIT_W:  w = '{cond: C_ALWAYS,   target: PC_EMIT,   rd: R_NONE,      act: A_NONE};
      default:    w = '{cond: C_ALWAYS,   target: PC_IDLE,   rd: R_NONE,      act: A_NONE};
    endcase
    return w;
  endfunction

endpackage

FILE: hw/rtl/max_heap_priority_queue_top.sv
`timescale 1ns / 1ps
// Top level of the max-heap priority queue: sequencer plus heap datapath.
// Depends on mhpq_pkg, mhpq_seq, mhpq_dpath.
//
//   channel  direction  handshake           beat payload
//   in       input      in_valid/in_stall   in_item_t  {operation, data_value}
//   out      output     out_valid/out_stall out_item_t {status, removed_value, entry_total}
//
// One beat at a time; in_stall is low only while the sequencer sits at its idle step.
// Insert climbs from a new leaf position toward the root; remove takes the root and sifts
// the last entry down from there, unless the root was the last entry; errors go straight
// to the emit step. The loop is one store read and one compare/write per level.
// Reset clears the entry count and the sequencer; the store needs no clearing pass.
// A stalled result holds the sequencer in its emit and emit-wait steps until out_stall drops.
module max_heap_priority_queue_top
  import mhpq_pkg::*;
#(
  parameter int CAPACITY = MHPQ_CAPACITY
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  ctrl_t  ctrl;
  flags_t flags;

  mhpq_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .flags    (flags),
    .ctrl     (ctrl)
  );

  mhpq_dpath #(
    .CAPACITY (CAPACITY)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (ctrl),
    .in_valid  (in_valid),
    .in_item   (in_item),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_item  (out_item),
    .flags     (flags)
  );

  assign in_stall = !ctrl.idle;

endmodule

FILE: hw/rtl/mhpq_seq.sv
`timescale 1ns / 1ps
// Microcode sequencer: step counter, control store lookup and branch select.
// Depends on mhpq_pkg.
module mhpq_seq
  import mhpq_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   in_valid,
  input  flags_t flags,
  output ctrl_t  ctrl
);

  logic [UPC_W-1:0] pc_r, pc_nxt;
  uword_t           uw;
  logic             take;

  always_comb begin
    uw = ucode(pc_r);
    case (uw.cond)
      C_NEVER:    take = 1'b0;
      C_ALWAYS:   take = 1'b1;
      C_NO_BEAT:  take = !in_valid;
      C_IS_INS:   take = flags.is_ins;
      C_ERR:      take = flags.err;
      C_LAST_ONE: take = flags.last_one;
      C_NO_LEFT:  take = flags.no_left;
      C_DN_MOVE:  take = flags.dn_move;
      C_AT_ROOT:  take = flags.at_root;
      C_UP_MOVE:  take = flags.up_move;
      C_OUT_FREE: take = flags.out_free;
      default:    take = 1'b1;
    endcase
    pc_nxt    = take ? uw.target : pc_r + 1'b1;
    ctrl.rd   = uw.rd;
    ctrl.act  = uw.act;
    ctrl.idle = (pc_r == PC_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= PC_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

FILE: hw/rtl/mhpq_dpath.sv
`timescale 1ns / 1ps
// Heap datapath: entry store, position/count/key registers, compares, result register.
// Depends on mhpq_pkg; driven by mhpq_seq.
module mhpq_dpath
  import mhpq_pkg::*;
#(
  parameter int CAPACITY = MHPQ_CAPACITY
) (
  input  logic      clk,
  input  logic      rst_n,
  input  ctrl_t     ctrl,
  input  logic      in_valid,
  input  in_item_t  in_item,
  input  logic      out_stall,
  output logic      out_valid,
  output out_item_t out_item,
  output flags_t    flags
);

  localparam int AW = $clog2(CAPACITY);
  localparam int PW = $clog2(CAPACITY + 1);

  logic signed [KEY_W-1:0] mem [CAPACITY];

  logic [PW-1:0]           cnt_r, pos_r;
  logic signed [KEY_W-1:0] key_r, removed_r, rd_a_r, rd_b_r;
  logic [1:0]              status_r;
  logic                    ins_r;
  logic                    out_valid_r;
  out_item_t               out_item_r;

  logic [PW:0]             left_pos, right_pos, cnt_ext, lchild_m1;
  logic [PW-1:0]           pos_m1, cnt_m1, par_m1, child_pos;
  logic [AW-1:0]           addr_a, addr_b, addr_w;
  logic signed [KEY_W-1:0] child_val, wdata;
  logic                    right_ok, pick_right, we, rd_en;
  logic [1:0]              status_nxt;
  logic [PW+TOTAL_W-1:0]   total_ext;

  always_comb begin
    pos_m1     = pos_r - 1'b1;
    cnt_m1     = cnt_r - 1'b1;
    par_m1     = (pos_r >> 1) - 1'b1;
    left_pos   = {pos_r, 1'b0};
    right_pos  = {pos_r, 1'b1};
    lchild_m1  = {pos_m1, 1'b1};
    cnt_ext    = {1'b0, cnt_r};
    right_ok   = (right_pos <= cnt_ext);
    pick_right = right_ok && (rd_b_r > rd_a_r);
    child_val  = pick_right ? rd_b_r : rd_a_r;
    child_pos  = pick_right ? right_pos[PW-1:0] : left_pos[PW-1:0];

    flags.err      = (status_r != ST_OK);
    flags.is_ins   = ins_r;
    flags.last_one = (cnt_r == PW'(1));
    flags.no_left  = (left_pos > cnt_ext);
    flags.dn_move  = (child_val > key_r);
    flags.at_root  = (pos_r == PW'(1));
    flags.up_move  = (key_r > rd_a_r);
    flags.out_free = !out_valid_r || !out_stall;

    if (in_item.operation == OP_REMOVE && cnt_r == '0) begin
      status_nxt = ST_EMPTY;
    end else if (in_item.operation == OP_INSERT && cnt_r >= PW'(CAPACITY)) begin
      status_nxt = ST_FULL;
    end else begin
      status_nxt = ST_OK;
    end

    rd_en = (ctrl.rd != R_NONE);
    case (ctrl.rd)
      R_ROOT_LAST: begin
        addr_a = '0;
        addr_b = cnt_m1[AW-1:0];
      end
      R_CHILDREN: begin
        addr_a = lchild_m1[AW-1:0];
        addr_b = left_pos[AW-1:0];
      end
      R_PARENT: begin
        addr_a = par_m1[AW-1:0];
        addr_b = par_m1[AW-1:0];
      end
      default: begin
        addr_a = '0;
        addr_b = '0;
      end
    endcase

    addr_w = pos_m1[AW-1:0];
    case (ctrl.act)
      A_UP_STEP: begin
        we    = flags.up_move;
        wdata = rd_a_r;
      end
      A_DN_STEP: begin
        we    = flags.dn_move;
        wdata = child_val;
      end
      A_PLACE: begin
        we    = 1'b1;
        wdata = key_r;
      end
      default: begin
        we    = 1'b0;
        wdata = key_r;
      end
    endcase

    total_ext = {{TOTAL_W{1'b0}}, cnt_r};
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr_w] <= wdata;
    end
    if (rd_en) begin
      rd_a_r <= mem[addr_a];
      rd_b_r <= mem[addr_b];
    end
  end

  always_ff @(posedge clk) begin
    case (ctrl.act)
      A_LOAD: begin
        if (in_valid) begin
          ins_r     <= (in_item.operation == OP_INSERT);
          key_r     <= in_item.data_value;
          status_r  <= status_nxt;
          removed_r <= '0;
        end
      end
      A_REM_START: begin
        removed_r <= rd_a_r;
        key_r     <= rd_b_r;
        pos_r     <= PW'(1);
      end
      A_INS_START: begin
        pos_r <= cnt_r + 1'b1;
      end
      A_UP_STEP: begin
        if (flags.up_move) begin
          pos_r <= pos_r >> 1;
        end
      end
      A_DN_STEP: begin
        if (flags.dn_move) begin
          pos_r <= child_pos;
        end
      end
      A_EMIT: begin
        if (flags.out_free) begin
          out_item_r.status        <= status_r;
          out_item_r.removed_value <= removed_r;
          out_item_r.entry_total   <= total_ext[TOTAL_W-1:0];
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (ctrl.act == A_INS_START) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (ctrl.act == A_REM_START) begin
        cnt_r <= cnt_r - 1'b1;
      end
      if (ctrl.act == A_EMIT && flags.out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

`ifndef SYNTH
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= PW'(CAPACITY))
    else $error("entry count above capacity");
  a_ins_room: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.act == A_INS_START |-> cnt_r < PW'(CAPACITY))
    else $error("insert started on a full heap");
  a_rem_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.act == A_REM_START |-> cnt_r != '0)
    else $error("remove started on an empty heap");
  a_wr_range: assert property (@(posedge clk) disable iff (!rst_n)
    we |-> (pos_r != '0 && pos_r <= cnt_r))
    else $error("store write outside held entries");
  a_up_not_root: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.act == A_UP_STEP |-> pos_r != PW'(1))
    else $error("sift-up step at the root");
`endif

endmodule
